>>> rtl/core/global_affine_gap_alignment_score_top_macros.svh
// Assertion macros for the affine-gap alignment score block.
`ifndef GLOBAL_AFFINE_GAP_ALIGNMENT_SCORE_TOP_MACROS_SVH
`define GLOBAL_AFFINE_GAP_ALIGNMENT_SCORE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GAGS_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GAGS_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/core/gags_pkg.sv
// Shared constants and types of the affine-gap alignment score block.
`default_nettype none

package gags_pkg;

    localparam int MAX_QUERY_DEF  = 256;
    localparam int SCORE_BITS_DEF = 21;

    localparam int RES_W      = 8;
    localparam int OPEN_W     = 7;
    localparam int EXT_W      = 5;
    localparam int MATCH_W    = 4;
    localparam int MISM_W     = 5;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SUBJ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXTEND    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_BONUS   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH_COST = 4'd3;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    typedef struct packed {
        logic signed [OPEN_W-1:0]  gap_open;
        logic signed [EXT_W-1:0]   gap_extend;
        logic        [MATCH_W-1:0] match_bonus;
        logic signed [MISM_W-1:0]  mismatch_cost;
    } t_cfg;

    // Control part of a token moving down the cell chain.
    typedef struct packed {
        logic valid;
        logic is_row;   // 1: subject row, 0: row initialization
        logic last;
    } t_tok_ctl;

    localparam t_cfg CFG_RST = '{
        gap_open:      -7'sd11,
        gap_extend:    -5'sd1,
        match_bonus:   4'd2,
        mismatch_cost: -5'sd1
    };

endpackage

`default_nettype wire

>>> rtl/core/gags_head.sv
// Chain entry: builds the start-of-row F value (open + extend * row) for each token.
`default_nettype none

module gags_head #(
    parameter int SCORE_BITS = gags_pkg::SCORE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  gags_pkg::t_cfg                     i_cfg,
    input  gags_pkg::t_tok_ctl                 i_ctl,
    input  wire [gags_pkg::RES_W-1:0]          i_res,
    input  wire [gags_pkg::ROW_W-1:0]          i_row,
    input  wire                                i_first,
    output gags_pkg::t_tok_ctl                 o_ctl,
    output logic [gags_pkg::RES_W-1:0]         o_res,
    output logic signed [SCORE_BITS-1:0]       o_f,
    output logic signed [SCORE_BITS-1:0]       o_h,
    output logic signed [SCORE_BITS-1:0]       o_diag
);

    localparam int PW = gags_pkg::EXT_W + gags_pkg::ROW_W + 1;
    localparam int SW = ((SCORE_BITS > PW) ? SCORE_BITS : PW) + 1;

    localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] LO = {{(SW-SCORE_BITS+1){1'b1}}, {(SCORE_BITS-1){1'b0}}};
    localparam logic signed [SW-1:0] HI = {{(SW-SCORE_BITS+1){1'b0}}, {(SCORE_BITS-1){1'b1}}};

    gags_pkg::t_tok_ctl            r1_ctl, r2_ctl, r3_ctl;
    logic [gags_pkg::RES_W-1:0]    r1_res, r2_res, r3_res;
    logic [gags_pkg::ROW_W-1:0]    r1_row;
    logic                          r1_first, r2_first, r3_first;
    logic signed [PW-1:0]          r2_prod;
    logic signed [SCORE_BITS-1:0]  r3_f;

    logic signed [PW-1:0]          n2_prod;
    logic signed [SW-1:0]          sum;
    logic signed [SCORE_BITS-1:0]  n3_f;

    assign n2_prod = $signed(i_cfg.gap_extend) * $signed({1'b0, r1_row});
    assign sum     = SW'(r2_prod) + SW'(i_cfg.gap_open);

    always_comb begin
        if (sum < LO) begin
            n3_f = SMIN;
        end else if (sum > HI) begin
            n3_f = SMAX;
        end else begin
            n3_f = sum[SCORE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_res   <= i_res;
        r1_row   <= i_ctl.is_row ? i_row : '0;   // init token yields E of column 1 = open
        r1_first <= i_first;
        r2_res   <= r1_res;
        r2_prod  <= n2_prod;
        r2_first <= r1_first;
        r3_res   <= r2_res;
        r3_f     <= n3_f;
        r3_first <= r2_first;
    end

    assign o_ctl  = r3_ctl;
    assign o_res  = r3_res;
    assign o_f    = r3_f;
    assign o_h    = SMIN;
    // H of column 0 is zero only above the first row.
    assign o_diag = r3_first ? '0 : SMIN;

endmodule

`default_nettype wire

>>> rtl/core/gags_cell.sv
// One query column: holds its residue, E and H, and updates them as tokens pass.
`default_nettype none

module gags_cell #(
    parameter int SCORE_BITS = gags_pkg::SCORE_BITS_DEF,
    parameter int QLW        = 9,
    parameter int IDX        = 1
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  gags_pkg::t_cfg                     i_cfg,
    input  wire [QLW-1:0]                      i_qlen,
    input  wire                                i_ld_en,
    input  wire [gags_pkg::RES_W-1:0]          i_ld_res,
    input  gags_pkg::t_tok_ctl                 i_ctl,
    input  wire [gags_pkg::RES_W-1:0]          i_res,
    input  wire signed [SCORE_BITS-1:0]        i_f,
    input  wire signed [SCORE_BITS-1:0]        i_h,
    input  wire signed [SCORE_BITS-1:0]        i_diag,
    input  wire signed [SCORE_BITS-1:0]        i_score,
    output gags_pkg::t_tok_ctl                 o_ctl,
    output logic [gags_pkg::RES_W-1:0]         o_res,
    output logic signed [SCORE_BITS-1:0]       o_f,
    output logic signed [SCORE_BITS-1:0]       o_h,
    output logic signed [SCORE_BITS-1:0]       o_diag,
    output logic signed [SCORE_BITS-1:0]       o_score
);

    localparam logic [QLW-1:0] POS  = QLW'(IDX);
    localparam logic [QLW-1:0] SLOT = QLW'(IDX - 1);

    localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic signed [SCORE_BITS-1:0] SMAX = {1'b0, {(SCORE_BITS-1){1'b1}}};

    // Saturating add; a minus-infinity first operand absorbs.
    function automatic logic signed [SCORE_BITS-1:0] f_sadd(
        input logic signed [SCORE_BITS-1:0] a,
        input logic signed [SCORE_BITS-1:0] b
    );
        logic signed [SCORE_BITS:0] s;
        s = {a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b};
        if (a == SMIN) begin
            return SMIN;
        end else if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
            return s[SCORE_BITS] ? SMIN : SMAX;
        end else begin
            return s[SCORE_BITS-1:0];
        end
    endfunction

    function automatic logic signed [SCORE_BITS-1:0] f_max(
        input logic signed [SCORE_BITS-1:0] a,
        input logic signed [SCORE_BITS-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    logic [gags_pkg::RES_W-1:0]    r_q;
    logic signed [SCORE_BITS-1:0]  r_e, r_h;
    gags_pkg::t_tok_ctl            r_ctl;
    logic [gags_pkg::RES_W-1:0]    r_res;
    logic signed [SCORE_BITS-1:0]  r_f, r_h_o, r_diag, r_score;

    logic signed [SCORE_BITS-1:0]  open_s, ext_s, match_s, mism_s;
    logic signed [SCORE_BITS-1:0]  e_new, f_new, d_new, h_new, f_init;

    assign open_s  = SCORE_BITS'(i_cfg.gap_open);
    assign ext_s   = SCORE_BITS'(i_cfg.gap_extend);
    assign match_s = SCORE_BITS'(i_cfg.match_bonus);
    assign mism_s  = SCORE_BITS'(i_cfg.mismatch_cost);

    assign e_new  = f_max(f_sadd(r_e, ext_s), f_sadd(r_h, open_s));
    assign f_new  = f_max(f_sadd(i_f, ext_s), f_sadd(i_h, open_s));
    assign d_new  = f_sadd(i_diag, (r_q == i_res) ? match_s : mism_s);
    assign h_new  = f_max(f_max(e_new, f_new), d_new);
    // Init token carries E of this column; the next one gets one more extend.
    assign f_init = f_sadd(i_f, ext_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_en && i_qlen == SLOT) begin
            r_q <= i_ld_res;
        end
        r_res <= i_res;
        if (i_ctl.valid) begin
            if (i_ctl.is_row) begin
                r_e     <= e_new;
                r_h     <= h_new;
                r_f     <= f_new;
                r_h_o   <= h_new;
                r_diag  <= r_h;
                r_score <= (i_qlen == POS) ? h_new : i_score;
            end else begin
                r_e     <= i_f;
                r_h     <= SMIN;
                r_f     <= f_init;
                r_h_o   <= SMIN;
                r_diag  <= SMIN;
                r_score <= i_score;
            end
        end
    end

    assign o_ctl   = r_ctl;
    assign o_res   = r_res;
    assign o_f     = r_f;
    assign o_h     = r_h_o;
    assign o_diag  = r_diag;
    assign o_score = r_score;

endmodule

`default_nettype wire

>>> rtl/core/global_affine_gap_alignment_score_top.sv
// Top level: query loading, subject streaming through the cell chain, result output.
//
// Input stream (s_axis): tuser selects the item kind (0 = query residue, 1 = subject
// residue), tdata carries the residue byte, tlast marks the final query or subject
// residue. Query residues are stored one per cycle; those beyond MAX_QUERY are dropped
// and flagged. Subject residues are taken one per cycle and each one travels down a
// chain of MAX_QUERY cells, one cell per cycle, updating one column per cell.
// Output stream (m_axis): one result per subject sequence; tdata = score, minus
// infinity being the lowest code; tuser = query truncated flag.
// Path of a result: from the last subject transfer it goes through two entry stages after
// the one that takes the transfer, MAX_QUERY cells, then the pending and output registers,
// where m_axis_tvalid rises. From that transfer until the result reaches the output
// register the input stream is held off; a new query may then load while the result
// still waits to be taken.
// Stall: a result not taken is held in the output register; one more result may wait
// in the stage behind it, and the input stays closed until that one moves up.
// Config port: writes are taken only while the chain holds no tokens.
// Reset: control and config registers take their default values, the query is empty, query loading expected.
`default_nettype none

module global_affine_gap_alignment_score_top #(
    parameter int MAX_QUERY  = gags_pkg::MAX_QUERY_DEF,
    parameter int SCORE_BITS = gags_pkg::SCORE_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire [gags_pkg::RES_W-1:0]             s_axis_tdata,   // [7:0] residue
    input  wire                                   s_axis_tlast,
    input  wire                                   s_axis_tuser,   // [0] action
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [((SCORE_BITS+7)/8)*8-1:0]       m_axis_tdata,   // [SCORE_BITS-1:0] score
    output logic                                  m_axis_tuser,   // [0] query_truncated
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [gags_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [gags_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int QLW   = $clog2(MAX_QUERY + 1);
    localparam int OUT_W = ((SCORE_BITS + 7) / 8) * 8;
    localparam int CNT_W = $clog2(MAX_QUERY + 5);
    localparam logic [QLW-1:0] QLEN_MAX = QLW'(MAX_QUERY);

    localparam logic signed [SCORE_BITS-1:0] SMIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    gags_pkg::t_cfg                r_cfg;
    logic [QLW-1:0]                r_qlen;
    logic                          r_ovf, r_loading, r_first, r_drain;
    logic [gags_pkg::ROW_W-1:0]    r_row;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_pend_v, r_pend_trunc;
    logic [SCORE_BITS-1:0]         r_pend_score;
    logic                          r_out_v, r_out_trunc;
    logic [SCORE_BITS-1:0]         r_out_score;

    logic                          in_xfer, ld_xfer, sub_xfer, ld_en, cfg_xfer;
    logic                          tail_done, pend_move, out_free;
    gags_pkg::t_tok_ctl            go_ctl;

    gags_pkg::t_tok_ctl            c_ctl   [0:MAX_QUERY];
    logic [gags_pkg::RES_W-1:0]    c_res   [0:MAX_QUERY];
    logic signed [SCORE_BITS-1:0]  c_f     [0:MAX_QUERY];
    logic signed [SCORE_BITS-1:0]  c_h     [0:MAX_QUERY];
    logic signed [SCORE_BITS-1:0]  c_diag  [0:MAX_QUERY];
    logic signed [SCORE_BITS-1:0]  c_score [0:MAX_QUERY];

    assign s_axis_tready = !r_drain;
    assign o_cfg_ready   = !r_drain && (r_cnt == '0);

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign ld_xfer  = in_xfer && (s_axis_tuser == gags_pkg::ACT_LOAD) && r_loading;
    assign sub_xfer = in_xfer && (s_axis_tuser == gags_pkg::ACT_SUBJ) && !r_loading;
    assign ld_en    = ld_xfer && (r_qlen != QLEN_MAX);
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;

    // Last query residue launches a row initialization token.
    assign go_ctl.valid  = (ld_xfer && s_axis_tlast) || sub_xfer;
    assign go_ctl.is_row = sub_xfer;
    assign go_ctl.last   = s_axis_tlast;

    assign tail_done = c_ctl[MAX_QUERY].valid && c_ctl[MAX_QUERY].is_row
                       && c_ctl[MAX_QUERY].last;
    assign out_free  = !r_out_v || m_axis_tready;
    assign pend_move = r_pend_v && out_free;

    gags_head #(
        .SCORE_BITS (SCORE_BITS)
    ) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (go_ctl),
        .i_res   (s_axis_tdata),
        .i_row   (r_row),
        .i_first (r_first),
        .o_ctl   (c_ctl[0]),
        .o_res   (c_res[0]),
        .o_f     (c_f[0]),
        .o_h     (c_h[0]),
        .o_diag  (c_diag[0])
    );

    assign c_score[0] = SMIN;

    for (genvar g = 1; g <= MAX_QUERY; g++) begin : g_cell
        gags_cell #(
            .SCORE_BITS (SCORE_BITS),
            .QLW        (QLW),
            .IDX        (g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (r_cfg),
            .i_qlen   (r_qlen),
            .i_ld_en  (ld_en),
            .i_ld_res (s_axis_tdata),
            .i_ctl    (c_ctl[g-1]),
            .i_res    (c_res[g-1]),
            .i_f      (c_f[g-1]),
            .i_h      (c_h[g-1]),
            .i_diag   (c_diag[g-1]),
            .i_score  (c_score[g-1]),
            .o_ctl    (c_ctl[g]),
            .o_res    (c_res[g]),
            .o_f      (c_f[g]),
            .o_h      (c_h[g]),
            .o_diag   (c_diag[g]),
            .o_score  (c_score[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg     <= gags_pkg::CFG_RST;
            r_qlen    <= '0;
            r_ovf     <= 1'b0;
            r_loading <= 1'b1;
            r_first   <= 1'b0;
            r_drain   <= 1'b0;
            r_row     <= '0;
            r_cnt     <= '0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    gags_pkg::CFG_GAP_OPEN:
                        r_cfg.gap_open <= i_cfg_data[gags_pkg::OPEN_W-1:0];
                    gags_pkg::CFG_GAP_EXTEND:
                        r_cfg.gap_extend <= i_cfg_data[gags_pkg::EXT_W-1:0];
                    gags_pkg::CFG_MATCH_BONUS:
                        r_cfg.match_bonus <= i_cfg_data[gags_pkg::MATCH_W-1:0];
                    gags_pkg::CFG_MISMATCH_COST:
                        r_cfg.mismatch_cost <= i_cfg_data[gags_pkg::MISM_W-1:0];
                    default: ;
                endcase
            end

            if (ld_xfer) begin
                if (ld_en) begin
                    r_qlen <= r_qlen + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
                if (s_axis_tlast) begin
                    r_loading <= 1'b0;
                    r_row     <= '0;
                    r_first   <= 1'b1;
                end
            end

            if (sub_xfer) begin
                r_first <= 1'b0;
                if (r_row != gags_pkg::ROW_MAX) begin
                    r_row <= r_row + 1'b1;
                end
                if (s_axis_tlast) begin
                    r_drain   <= 1'b1;
                    r_loading <= 1'b1;
                end
            end

            // Query length stays put until the final row has left the last cell of the chain.
            if (tail_done) begin
                r_pend_v <= 1'b1;
                r_qlen   <= '0;
                r_ovf    <= 1'b0;
            end

            if (pend_move) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
                r_drain  <= 1'b0;
            end else if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end

            case ({go_ctl.valid, c_ctl[MAX_QUERY].valid})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail_done) begin
            r_pend_score <= c_score[MAX_QUERY];
            r_pend_trunc <= r_ovf;
        end
        if (pend_move) begin
            r_out_score <= r_pend_score;
            r_out_trunc <= r_pend_trunc;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = OUT_W'(r_out_score);
    assign m_axis_tuser  = r_out_trunc;

endmodule

`default_nettype wire

>>> rtl/core/gags_chk.sv
// Port-level checker for the alignment score block, bound to the top level.
`default_nettype none

`include "global_affine_gap_alignment_score_top_macros.svh"

module gags_chk #(
    parameter int SCORE_BITS = gags_pkg::SCORE_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    input  wire                                   s_axis_tready,
    input  wire                                   s_axis_tlast,
    input  wire                                   s_axis_tuser,
    input  wire                                   m_axis_tvalid,
    input  wire                                   m_axis_tready,
    input  wire [((SCORE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    input  wire                                   m_axis_tuser,
    input  wire                                   o_cfg_ready
);

    `GAGS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    `GAGS_ASSERT_IMP(a_close_cause, i_clk, i_rst_n, $fell(s_axis_tready), $past(s_axis_tvalid && s_axis_tlast && s_axis_tuser == gags_pkg::ACT_SUBJ), "input closed without a final subject transfer")

    `GAGS_ASSERT_IMP(a_reopen, i_clk, i_rst_n, $rose(m_axis_tvalid), $rose(s_axis_tready), "result shown without input reopening")

    `GAGS_ASSERT_IMP(a_cfg_quiet, i_clk, i_rst_n, !s_axis_tready, !o_cfg_ready, "config open while a result is in flight")

endmodule

bind global_affine_gap_alignment_score_top gags_chk #(
    .SCORE_BITS (SCORE_BITS)
) u_gags_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .o_cfg_ready   (o_cfg_ready)
);

`default_nettype wire
